// ----- src/bf3w_pkg.sv -----
// Shared constants and types for the 3x3 box filter window core.
package bf3w_pkg;

    // Frame limits and pixel format.
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int PIXEL_BITS   = 16;
    localparam int MIN_SIZE     = 3;

    // Derived widths.
    localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
    localparam int SIZE_BITS    = 11;
    localparam int POS_BITS     = 10;
    localparam int COL_SUM_BITS = PIXEL_BITS + 2;
    localparam int SUM_BITS     = PIXEL_BITS + 4;
    localparam int CFG_IDX_BITS = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    // One line store entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] upper;
        logic signed [PIXEL_BITS-1:0] middle;
    } line_pair_t;

    // Control carried along with a pixel through the pipeline.
    typedef struct packed {
        logic                has_result;
        logic                last;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } pix_meta_t;

    // Control for one cell of the window row.
    typedef struct packed {
        logic shift_en;
    } cell_ctrl_t;

endpackage

// ----- src/bf3w_line_buf.sv -----
// Two-row line store as one memory with a registered read port and a write port.
module bf3w_line_buf (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [bf3w_pkg::ADDR_BITS-1:0] rd_addr,
    output bf3w_pkg::line_pair_t           rd_data,
    input  logic                           wr_en,
    input  logic [bf3w_pkg::ADDR_BITS-1:0] wr_addr,
    input  bf3w_pkg::line_pair_t           wr_data
);
    import bf3w_pkg::*;

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; holds its data while the pipeline stalls.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/bf3w_cell.sv -----
// One window column cell: holds the sum of a three-pixel column and passes it on.
module bf3w_cell (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  bf3w_pkg::cell_ctrl_t                     ctrl,
    input  logic signed [bf3w_pkg::COL_SUM_BITS-1:0] sum_in,
    output logic signed [bf3w_pkg::COL_SUM_BITS-1:0] sum_out
);
    import bf3w_pkg::*;

    logic signed [COL_SUM_BITS-1:0] sum_reg;

    // Take the neighbor's column whenever the window slides.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.shift_en)
        begin
            sum_reg <= sum_in;
        end
    end

    assign sum_out = sum_reg;

endmodule

// ----- src/box_filter_3x3_window_core.sv -----
// Top level of the 3x3 box filter: position counters, line store, window cells, output.
//
// Pixels enter in raster order on the input channel (in_valid, in_ready, pixel),
// one beat per pixel. Each pixel whose row and column are both at least 2 yields
// one beat on the output channel (out_valid, out_ready, window_sum, out_row,
// out_col, frame_last) carrying the exact sum of its 3x3 neighborhood; border
// pixels are stored and yield nothing. frame_last marks the final result.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// frame_width (index 0) or frame_height (index 1); sizes are clamped to 3..1024,
// and a write restarts the frame at row 0, column 0. Other indexes are ignored.
// Throughput is one pixel per clock while the receiver keeps up: the line store
// reads and writes one entry a cycle and the window is a row of three column
// cells that slide every beat. A result passes from the stage-one registers
// through the window cells and stage two into the output register.
// Reset sets both sizes to 5 and the position to the frame start; the line
// store is not cleared, since its entries are written before any result uses them.
// When the receiver stalls, the result waits in the output register while one
// more result and one more pixel move up; then in_ready drops.
module box_filter_3x3_window_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [bf3w_pkg::PIXEL_BITS-1:0]  pixel,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [bf3w_pkg::SUM_BITS-1:0]    window_sum,
    output logic [bf3w_pkg::POS_BITS-1:0]           out_row,
    output logic [bf3w_pkg::POS_BITS-1:0]           out_col,
    output logic                                    frame_last,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [bf3w_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [bf3w_pkg::SIZE_BITS-1:0]          cfg_data
);
    import bf3w_pkg::*;

    localparam int NUM_CELLS = 3;

    // Configuration and position state.
    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;
    logic [ADDR_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0]  row_reg;
    logic [SIZE_BITS-1:0] width_eff;
    logic [SIZE_BITS-1:0] height_eff;
    logic [SIZE_BITS-1:0] col_last;
    logic [SIZE_BITS-1:0] row_last;
    logic                 at_col_end;
    logic                 at_row_end;
    logic                 cfg_write;
    logic                 in_accept;

    // Pipeline stage registers.
    logic                         s1_valid_reg;
    logic signed [PIXEL_BITS-1:0] s1_px_reg;
    logic [ADDR_BITS-1:0]         s1_addr_reg;
    pix_meta_t                    s1_meta_reg;
    pix_meta_t                    s0_meta;
    logic                         s2_valid_reg;
    pix_meta_t                    s2_meta_reg;
    logic                         out_valid_reg;
    logic signed [SUM_BITS-1:0]   sum_reg;
    logic [POS_BITS-1:0]          row_out_reg;
    logic [POS_BITS-1:0]          col_out_reg;
    logic                         last_out_reg;

    logic                           out_free;
    logic                           s2_adv;
    logic                           s1_adv;
    line_pair_t                     rd_pair;
    line_pair_t                     wr_pair;
    logic signed [COL_SUM_BITS-1:0] new_col_sum;
    logic signed [COL_SUM_BITS-1:0] cell_sum [NUM_CELLS+1];
    cell_ctrl_t                     cell_ctrl;
    logic signed [SUM_BITS-1:0]     total_sum;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    // Handshake and stage advance.
    assign out_free  = !out_valid_reg || out_ready;
    assign s2_adv    = !s2_valid_reg || out_free;
    assign s1_adv    = s1_valid_reg && s2_adv;
    assign in_ready  = !s1_valid_reg || s2_adv;
    assign in_accept = in_valid && in_ready;

    // Clamp the configured sizes to the supported range.
    always_comb
    begin
        priority if (width_reg < SIZE_BITS'(MIN_SIZE))
            width_eff = SIZE_BITS'(MIN_SIZE);
        else if (width_reg > SIZE_BITS'(MAX_WIDTH))
            width_eff = SIZE_BITS'(MAX_WIDTH);
        else
            width_eff = width_reg;

        priority if (height_reg < SIZE_BITS'(MIN_SIZE))
            height_eff = SIZE_BITS'(MIN_SIZE);
        else if (height_reg > SIZE_BITS'(MAX_HEIGHT))
            height_eff = SIZE_BITS'(MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    assign col_last   = width_eff - SIZE_BITS'(1);
    assign row_last   = height_eff - SIZE_BITS'(1);
    assign at_col_end = (SIZE_BITS'(col_reg) == col_last);
    assign at_row_end = (SIZE_BITS'(row_reg) == row_last);

    // Result flags and output position of the incoming pixel.
    always_comb
    begin
        s0_meta.has_result = (row_reg >= ROW_BITS'(2)) && (col_reg >= ADDR_BITS'(2));
        s0_meta.last       = at_col_end && at_row_end;
        s0_meta.row        = POS_BITS'(row_reg - ROW_BITS'(2));
        s0_meta.col        = POS_BITS'(col_reg - ADDR_BITS'(2));
    end

    // Configuration registers and the raster position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_BITS'(5);
            height_reg <= SIZE_BITS'(5);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (at_col_end)
            begin
                col_reg <= '0;
                row_reg <= at_row_end ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_reg <= col_reg + ADDR_BITS'(1);
            end
        end
    end

    // Line store: read the column on accept, write it back one stage later.
    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = s1_px_reg;

    bf3w_line_buf u_line_buf (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (rd_pair),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_pair)
    );

    // Stage one: pixel waiting for its line store data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_px_reg   <= pixel;
            s1_addr_reg <= col_reg;
            s1_meta_reg <= s0_meta;
        end
    end

    // Sum of the new window column.
    assign new_col_sum = COL_SUM_BITS'(rd_pair.upper) + COL_SUM_BITS'(rd_pair.middle)
                       + COL_SUM_BITS'(s1_px_reg);

    // Window: a row of column cells sliding by one on each pixel.
    assign cell_ctrl.shift_en = s1_adv;
    assign cell_sum[0]        = new_col_sum;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cells
        bf3w_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .sum_in  (cell_sum[i]),
            .sum_out (cell_sum[i+1])
        );
    end

    // Stage two: result position waiting while the window settles.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_meta_reg.has_result;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // Total of the three column sums.
    assign total_sum = SUM_BITS'(cell_sum[1]) + SUM_BITS'(cell_sum[2])
                     + SUM_BITS'(cell_sum[3]);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_valid_reg && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_free)
        begin
            sum_reg      <= total_sum;
            row_out_reg  <= s2_meta_reg.row;
            col_out_reg  <= s2_meta_reg.col;
            last_out_reg <= s2_meta_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_sum = sum_reg;
    assign out_row    = row_out_reg;
    assign out_col    = col_out_reg;
    assign frame_last = last_out_reg;

endmodule

// ----- bench/box_filter_3x3_window_core_tb.sv -----
// Self-checking testbench for the 3x3 box filter window core: raster pixels in, window sums out.
`timescale 1ns / 100ps

module box_filter_3x3_window_core_tb;

    import bf3w_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;
    localparam int STALL_LEN    = 400;

    // One expected window result.
    typedef struct {
        logic signed [SUM_BITS-1:0] sum;
        logic [POS_BITS-1:0]        row;
        logic [POS_BITS-1:0]        col;
        logic                       last;
    } box_sum_t;

    // Ports of the block.
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [PIXEL_BITS-1:0] pixel = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [SUM_BITS-1:0]   window_sum;
    logic [POS_BITS-1:0]          out_row;
    logic [POS_BITS-1:0]          out_col;
    logic                         frame_last;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
    logic [SIZE_BITS-1:0]         cfg_data = '0;

    // Stimulus and checking state.
    logic signed [PIXEL_BITS-1:0] pixel_queue [$];
    box_sum_t                     expected_sums [$];
    int                           mismatch_count = 0;
    int                           send_idle_pct = 21;
    int                           recv_idle_pct = 78;
    int                           cycle_count = 0;
    logic                         stall_arm = 1'b0;
    logic                         stall_fired = 1'b0;
    int                           stall_left = 0;

    // Predictor copy of the registers, line stores, window and position.
    logic [SIZE_BITS-1:0]         width_reg = SIZE_BITS'(5);
    logic [SIZE_BITS-1:0]         height_reg = SIZE_BITS'(5);
    logic signed [PIXEL_BITS-1:0] upper_line [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] middle_line [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] win [3][3];
    int unsigned                  col_pos = 0;
    int unsigned                  row_pos = 0;

    box_filter_3x3_window_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .window_sum (window_sum),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Effective frame size after clamping to the supported range.
    function automatic int unsigned clamp_dim(input logic [SIZE_BITS-1:0] v,
                                              input int unsigned lim);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // Mostly full-range random pixels, with the extremes weighted in.
    function automatic logic signed [PIXEL_BITS-1:0] random_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return {1'b0, {(PIXEL_BITS-1){1'b1}}};
        if (pick == 1)
            return {1'b1, {(PIXEL_BITS-1){1'b0}}};
        return PIXEL_BITS'($urandom);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Register write as seen by the predictor; a known index restarts the frame.
    task automatic apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [SIZE_BITS-1:0] data);
        if (idx == REG_FRAME_WIDTH)
            width_reg = data;
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = data;
        else
            return;
        col_pos = 0;
        row_pos = 0;
    endtask

    // Slide the window by one pixel and queue the sum it completes, if any.
    task automatic advance_window(input logic signed [PIXEL_BITS-1:0] px);
        int unsigned w, h, c, r;
        int          acc;
        int          k, j;
        box_sum_t    res;
        logic signed [PIXEL_BITS-1:0] up, mid;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        if (c >= w)
            c = 0;
        if (r >= h)
            r = 0;
        up  = upper_line[c];
        mid = middle_line[c];
        for (k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = px;
        upper_line[c]  = mid;
        middle_line[c] = px;
        if (r >= 2 && c >= 2)
        begin
            acc = 0;
            for (k = 0; k < 3; k++)
                for (j = 0; j < 3; j++)
                    acc += win[k][j];
            res.sum  = SUM_BITS'(acc);
            res.row  = POS_BITS'(r - 2);
            res.col  = POS_BITS'(c - 2);
            res.last = (r == h - 1) && (c == w - 1);
            expected_sums.push_back(res);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // Wait until every pixel is in and every sum is out, then let the pipeline settle.
    task automatic drain_block();
        while (pixel_queue.size() != 0 || in_valid || expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write beat, after which valid drops.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [SIZE_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
        @(posedge clk);
    endtask

    task automatic push_pixels(input int n, input logic signed [PIXEL_BITS-1:0] value,
                               input bit random_fill);
        int i;
        for (i = 0; i < n; i++)
            pixel_queue.push_back(random_fill ? random_pixel() : value);
    endtask

    // Pixel driver: offers the head of the queue and predicts each accepted beat.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_window(pixel);
                pixel_queue.delete(0);
            end
            if (in_valid && !in_ready)
            begin
                // Beat still pending: hold valid and payload.
            end
            else if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                pixel    <= pixel_queue[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, started once when armed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
                stall_left <= stall_left - 1;
            else if (stall_arm && !stall_fired)
            begin
                stall_left  <= STALL_LEN;
                stall_fired <= 1'b1;
            end
        end
    end

    // Receiver ready with random idling.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result monitor: each beat against the oldest expected sum.
    always @(posedge clk)
    begin
        box_sum_t exp_sum;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
                flag_mismatch($sformatf("unexpected result sum=%0d row=%0d col=%0d",
                                        window_sum, out_row, out_col));
            else
            begin
                exp_sum = expected_sums.pop_front();
                if (window_sum !== exp_sum.sum)
                    flag_mismatch($sformatf("window_sum %0d, expected %0d at (%0d,%0d)",
                                            window_sum, exp_sum.sum, exp_sum.row,
                                            exp_sum.col));
                if (out_row !== exp_sum.row)
                    flag_mismatch($sformatf("out_row %0d, expected %0d",
                                            out_row, exp_sum.row));
                if (out_col !== exp_sum.col)
                    flag_mismatch($sformatf("out_col %0d, expected %0d",
                                            out_col, exp_sum.col));
                if (frame_last !== exp_sum.last)
                    flag_mismatch($sformatf("frame_last %b, expected %b at (%0d,%0d)",
                                            frame_last, exp_sum.last, exp_sum.row,
                                            exp_sum.col));
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("box_filter_3x3_window_core_tb: errors");
        $finish;
    end

    // Sequencer: reset, directed frames, random phases, oversized sizes, verdict.
    initial
    begin
        int          i;
        int          random_items;
        int          n_items;
        int unsigned pick, w, h, frame_len;
        for (i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 9; i++)
            win[i / 3][i % 3] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size 5x5: saturating-high pixels give the largest sum.
        push_pixels(13, {1'b0, {(PIXEL_BITS-1){1'b1}}}, 1'b0);
        drain_block();
        // An unknown index must leave the frame position alone.
        write_reg({CFG_IDX_BITS{1'b1}}, {SIZE_BITS{1'b1}});
        push_pixels(1, {1'b0, {(PIXEL_BITS-1){1'b1}}}, 1'b0);
        drain_block();
        // Sizes below the minimum act as 3x3; the lowest pixels give the smallest sum.
        write_reg(REG_FRAME_WIDTH, SIZE_BITS'(2));
        write_reg(REG_FRAME_HEIGHT, SIZE_BITS'(1));
        push_pixels(9, {1'b1, {(PIXEL_BITS-1){1'b0}}}, 1'b0);

        // Random phases: mostly whole frames, some partial frames and stray writes.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 78;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_block();
            if (send_idle_pct == 0 && !stall_arm)
            begin
                // Big frame while the receiver holds off, so the input backs up.
                write_reg(REG_FRAME_WIDTH, SIZE_BITS'(20));
                write_reg(REG_FRAME_HEIGHT, SIZE_BITS'(20));
                stall_arm <= 1'b1;
                n_items = 400;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    write_reg(CFG_IDX_BITS'($urandom_range(2, 255)), SIZE_BITS'($urandom));
                    n_items = $urandom_range(1, 30);
                end
                else
                begin
                    w = (pick == 1) ? $urandom_range(0, 2) : $urandom_range(3, 12);
                    h = (pick == 2) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                    write_reg(REG_FRAME_WIDTH, SIZE_BITS'(w));
                    if (pick != 3)
                        write_reg(REG_FRAME_HEIGHT, SIZE_BITS'(h));
                    frame_len = clamp_dim(width_reg, MAX_WIDTH) *
                                clamp_dim(height_reg, MAX_HEIGHT);
                    n_items = frame_len * $urandom_range(1, 2);
                    if ($urandom_range(0, 3) == 0)
                        n_items += $urandom_range(1, frame_len - 1);
                end
            end
            push_pixels(n_items, '0, 1'b1);
            random_items += n_items;
        end

        // Sizes above the maximum are clamped; a short run from the frame start.
        drain_block();
        write_reg(REG_FRAME_WIDTH, {SIZE_BITS{1'b1}});
        write_reg(REG_FRAME_HEIGHT, {SIZE_BITS{1'b1}});
        push_pixels(24, '0, 1'b1);

        drain_block();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("box_filter_3x3_window_core_tb: clean");
        else
            $display("box_filter_3x3_window_core_tb: errors");
        $finish;
    end

endmodule
